@@ rtl/core/groove_template_quantizer_macros.svh @@
// Assertion macros used by the groove template quantizer checker.
`ifndef GROOVE_TEMPLATE_QUANTIZER_MACROS_SVH
`define GROOVE_TEMPLATE_QUANTIZER_MACROS_SVH

// Same-cycle implication, sampled on clk and disabled while rst_n is low.
`define GTQ_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk and disabled while rst_n is low.
`define GTQ_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/core/gtq_pkg.sv @@
// Shared types and constants of the groove template quantizer.
package gtq_pkg;

    localparam int MAX_STEPS_DEF     = 256;
    localparam int POSITION_BITS_DEF = 32;

    localparam int TR_W        = 16;
    localparam int SC_W        = 9;
    localparam int IDX_W       = 8;
    localparam int OFF_W       = 17;
    localparam int POS_FIELD_W = 32;
    localparam int STEP_FIELD_W = 8;

    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 16;

    localparam int S_TDATA_W = 64;
    localparam int M_TDATA_W = 48;

    localparam int TR_RESET = 480;
    localparam int SC_RESET = 16;

    localparam logic [CFG_IDX_W-1:0] REG_TICK_RASTER = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_STEP_COUNT  = 8'd1;

    typedef enum logic
    {
        REQ_QUANTIZE = 1'b0,
        REQ_WRITE    = 1'b1
    } req_type_t;

    typedef struct packed
    {
        logic advance;
        logic valid;
    } pipe_ctl_t;

endpackage

@@ rtl/core/gtq_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
module gtq_ram #(
    parameter int WIDTH = gtq_pkg::OFF_W,
    parameter int DEPTH = gtq_pkg::MAX_STEPS_DEF
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [0:DEPTH-1];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ rtl/core/gtq_divider.sv @@
// Pipelined restoring divider, one quotient bit per stage, with a carried sideband.
module gtq_divider #(
    parameter int N = 32,
    parameter int D = 16,
    parameter int Q = 8,
    parameter int S = 1
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  gtq_pkg::pipe_ctl_t   ctl,
    input  logic [N-1:0]         dividend,
    input  logic [D-1:0]         divisor,
    input  logic [S-1:0]         side_in,
    output logic                 out_valid,
    output logic [Q-1:0]         quotient,
    output logic [D-1:0]         remainder,
    output logic [S-1:0]         side_out
);

    // The dividend must be below divisor * 2**Q and the divisor must stay
    // stable while items are in flight.
    logic         vld_reg  [0:Q];
    logic [D-1:0] rem_reg  [0:Q];
    logic [Q-1:0] low_reg  [0:Q];
    logic [Q-1:0] quo_reg  [0:Q];
    logic [S-1:0] side_reg [0:Q];

    logic [D-1:0] rem_next [1:Q];
    logic [Q-1:0] low_next [1:Q];
    logic [Q-1:0] quo_next [1:Q];
    logic [D:0]   trial    [0:Q-1];
    logic         take_bit [0:Q-1];

    always_comb
    begin
        for (int k = 0; k < Q; k++)
        begin
            trial[k]      = {rem_reg[k], low_reg[k][Q-1]};
            take_bit[k]   = (trial[k] >= {1'b0, divisor});
            rem_next[k+1] = take_bit[k] ? D'(trial[k] - {1'b0, divisor}) : D'(trial[k]);
            quo_next[k+1] = Q'({quo_reg[k], take_bit[k]});
            low_next[k+1] = low_reg[k] << 1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k <= Q; k++)
            begin
                vld_reg[k] <= 1'b0;
            end
        end
        else if (ctl.advance)
        begin
            vld_reg[0] <= ctl.valid;
            for (int k = 1; k <= Q; k++)
            begin
                vld_reg[k] <= vld_reg[k-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.advance)
        begin
            rem_reg[0]  <= D'(dividend >> Q);
            low_reg[0]  <= Q'(dividend);
            quo_reg[0]  <= '0;
            side_reg[0] <= side_in;
            for (int k = 1; k <= Q; k++)
            begin
                rem_reg[k]  <= rem_next[k];
                low_reg[k]  <= low_next[k];
                quo_reg[k]  <= quo_next[k];
                side_reg[k] <= side_reg[k-1];
            end
        end
    end

    assign out_valid = vld_reg[Q];
    assign quotient  = quo_reg[Q];
    assign remainder = rem_reg[Q];
    assign side_out  = side_reg[Q];

endmodule

@@ rtl/core/groove_template_quantizer.sv @@
// Top level of the groove template quantizer.
// Usage: items enter on the s_ channel (s_tuser = request kind, 0 quantize, 1 write an
// offset) and leave on the m_ channel, exactly one result item per input item, in order.
// A quantize item returns the position snapped to the nearest groove step plus that
// step's stored offset; a write item stores one offset and returns an all-zero result.
// The configuration channel writes tick_raster (index 0) and step_count (index 1); it is
// always ready and should only be used while no item is in flight.
// From acceptance to m_tvalid an item passes through the two pipelined dividers, one
// stage per quotient bit, then the rounding stage, the offset table read and the final
// add and clamp into the output register.
// Throughput is one item per cycle while the output does not stall.
// After reset the offset table is cleared one entry per cycle; s_tready stays low until
// that sweep has finished.
// When the receiver stalls, one further result is held in a skid register behind the
// output register; once that is full the whole pipeline freezes and s_tready drops.
module groove_template_quantizer #(
    parameter int MAX_STEPS     = gtq_pkg::MAX_STEPS_DEF,
    parameter int POSITION_BITS = gtq_pkg::POSITION_BITS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // [31:0] position, [39:32] entry_index, [56:40] entry_offset, rest zero.
    input  logic [gtq_pkg::S_TDATA_W-1:0]    s_tdata,
    // [0] req_type.
    input  logic                             s_tuser,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // [31:0] quantized_position, [39:32] chosen_step, [40] clamped, rest zero.
    output logic [gtq_pkg::M_TDATA_W-1:0]    m_tdata,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [gtq_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [gtq_pkg::CFG_DATA_W-1:0]   cfg_data
);

    localparam int PW     = (POSITION_BITS < gtq_pkg::POS_FIELD_W) ?
                            POSITION_BITS : gtq_pkg::POS_FIELD_W;
    localparam int STEP_W = $clog2(MAX_STEPS);
    localparam int SCE_W  = $clog2(MAX_STEPS + 1);
    localparam int TR_W   = gtq_pkg::TR_W;
    localparam int CYC_W  = TR_W + SCE_W;
    localparam int OFF_W  = gtq_pkg::OFF_W;
    localparam int IDX_W  = gtq_pkg::IDX_W;
    localparam int SUM_W  = PW + 1;
    localparam int RES_W  = PW + 3;

    localparam int SB_POS = 1;
    localparam int SB_IDX = SB_POS + PW;
    localparam int SB_OFF = SB_IDX + IDX_W;
    localparam int SB_W   = SB_OFF + OFF_W;

    localparam int SC_RST  = (gtq_pkg::SC_RESET > MAX_STEPS) ? MAX_STEPS : gtq_pkg::SC_RESET;
    localparam int CYC_RST = SC_RST * gtq_pkg::TR_RESET;

    localparam logic [PW-1:0] POS_MAX = '1;

    // Configuration, held as effective values.
    logic [TR_W-1:0]  tr_reg, tr_next, tr_in;
    logic [SCE_W-1:0] sc_reg, sc_next, sc_in;
    logic [CYC_W-1:0] cycle_reg, cycle_next;
    logic [gtq_pkg::SC_W-1:0] sc_raw;

    // Flow control.
    logic en;
    logic s_accept;
    gtq_pkg::pipe_ctl_t a_ctl, b_ctl;

    // Table clearing after reset.
    logic              clr_active_reg;
    logic [STEP_W-1:0] clr_addr_reg;

    // Divider links.
    logic [SB_W-1:0]  a_side_in, a_side, b_side;
    logic             a_valid, b_valid;
    logic [CYC_W-1:0] a_rem;
    logic [STEP_W-1:0] b_quo;
    logic [TR_W-1:0]  b_rem;

    // Rounding stage.
    gtq_pkg::req_type_t b_type;
    logic [PW-1:0]     b_pos;
    logic [IDX_W-1:0]  b_idx;
    logic [OFF_W-1:0]  b_off;
    logic              round_up;
    logic [STEP_W:0]   step_inc;
    logic              wrap;
    logic [STEP_W-1:0] step_sel;

    logic               c_valid_reg;
    gtq_pkg::req_type_t c_type_reg, c_type_next;
    logic [STEP_W-1:0]  c_addr_reg, c_addr_next;
    logic [SUM_W-1:0]   c_sum_reg, c_sum_next;
    logic [OFF_W-1:0]   c_wdata_reg;
    logic               c_wr_reg, c_wr_next;

    // Table access.
    logic              ram_we;
    logic [STEP_W-1:0] ram_waddr;
    logic [OFF_W-1:0]  ram_wdata;
    logic [OFF_W-1:0]  ram_rdata;

    // Result stage.
    logic               d_valid_reg;
    gtq_pkg::req_type_t d_type_reg;
    logic [STEP_W-1:0]  d_step_reg;
    logic [SUM_W-1:0]   d_sum_reg;
    logic signed [OFF_W-1:0] off_s;
    logic signed [RES_W-1:0] res;
    logic [PW-1:0]      q_val;
    logic               clamp;
    logic [gtq_pkg::M_TDATA_W-1:0] new_data;
    logic               new_valid;

    // Output register and skid.
    logic                          out_valid_reg, out_valid_next;
    logic [gtq_pkg::M_TDATA_W-1:0] out_data_reg, out_data_next;
    logic                          skid_valid_reg, skid_valid_next;
    logic [gtq_pkg::M_TDATA_W-1:0] skid_data_reg, skid_data_next;
    logic                          take;

    // ---------------------------------------------------------------- config
    assign cfg_ready = 1'b1;
    assign sc_raw    = cfg_data[gtq_pkg::SC_W-1:0];
    assign tr_in     = (cfg_data == '0) ? TR_W'(1) : cfg_data;

    always_comb
    begin
        priority if (sc_raw == '0)
        begin
            sc_in = SCE_W'(1);
        end
        else if (32'(sc_raw) > 32'(MAX_STEPS))
        begin
            sc_in = SCE_W'(MAX_STEPS);
        end
        else
        begin
            sc_in = SCE_W'(sc_raw);
        end
    end

    always_comb
    begin
        tr_next    = tr_reg;
        sc_next    = sc_reg;
        cycle_next = cycle_reg;
        if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                gtq_pkg::REG_TICK_RASTER:
                begin
                    tr_next    = tr_in;
                    cycle_next = CYC_W'(sc_reg) * CYC_W'(tr_in);
                end
                gtq_pkg::REG_STEP_COUNT:
                begin
                    sc_next    = sc_in;
                    cycle_next = CYC_W'(sc_in) * CYC_W'(tr_reg);
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tr_reg    <= TR_W'(gtq_pkg::TR_RESET);
            sc_reg    <= SCE_W'(SC_RST);
            cycle_reg <= CYC_W'(CYC_RST);
        end
        else
        begin
            tr_reg    <= tr_next;
            sc_reg    <= sc_next;
            cycle_reg <= cycle_next;
        end
    end

    // ---------------------------------------------------------- flow control
    assign en       = !skid_valid_reg;
    assign s_tready = en && !clr_active_reg;
    assign s_accept = s_tvalid && s_tready;

    assign a_ctl = '{advance: en, valid: s_accept};
    assign b_ctl = '{advance: en, valid: a_valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_active_reg <= 1'b1;
            clr_addr_reg   <= '0;
        end
        else if (clr_active_reg)
        begin
            if (clr_addr_reg == STEP_W'(MAX_STEPS - 1))
            begin
                clr_active_reg <= 1'b0;
            end
            else
            begin
                clr_addr_reg <= clr_addr_reg + STEP_W'(1);
            end
        end
    end

    // -------------------------------------------------------------- dividers
    assign a_side_in = {s_tdata[56:40], s_tdata[39:32], PW'(s_tdata[31:0]), s_tuser};

    gtq_divider #(
        .N (PW),
        .D (CYC_W),
        .Q (PW),
        .S (SB_W)
    ) u_cycle_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (a_ctl),
        .dividend  (a_side_in[SB_POS +: PW]),
        .divisor   (cycle_reg),
        .side_in   (a_side_in),
        .out_valid (a_valid),
        .quotient  (),
        .remainder (a_rem),
        .side_out  (a_side)
    );

    gtq_divider #(
        .N (CYC_W),
        .D (TR_W),
        .Q (STEP_W),
        .S (SB_W)
    ) u_step_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (b_ctl),
        .dividend  (a_rem),
        .divisor   (tr_reg),
        .side_in   (a_side),
        .out_valid (b_valid),
        .quotient  (b_quo),
        .remainder (b_rem),
        .side_out  (b_side)
    );

    // -------------------------------------------------------- rounding stage
    assign b_type = gtq_pkg::req_type_t'(b_side[0]);
    assign b_pos  = b_side[SB_POS +: PW];
    assign b_idx  = b_side[SB_IDX +: IDX_W];
    assign b_off  = b_side[SB_OFF +: OFF_W];

    always_comb
    begin
        round_up = (b_rem > (tr_reg >> 1));
        step_inc = {1'b0, b_quo} + (STEP_W + 1)'(1);
        wrap     = (32'(step_inc) == 32'(sc_reg));
        if (!round_up)
        begin
            step_sel = b_quo;
        end
        else if (wrap)
        begin
            step_sel = '0;
        end
        else
        begin
            step_sel = STEP_W'(step_inc);
        end
        // Cycle base plus step start equals the position less the in-step remainder.
        c_sum_next  = SUM_W'(b_pos) - SUM_W'(b_rem) + (round_up ? SUM_W'(tr_reg) : '0);
        c_type_next = b_type;
        if (b_type == gtq_pkg::REQ_WRITE)
        begin
            c_addr_next = STEP_W'(b_idx);
            c_wr_next   = (32'(b_idx) < 32'(MAX_STEPS));
        end
        else
        begin
            c_addr_next = step_sel;
            c_wr_next   = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c_valid_reg <= 1'b0;
            d_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            c_valid_reg <= b_valid;
            d_valid_reg <= c_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            c_type_reg  <= c_type_next;
            c_addr_reg  <= c_addr_next;
            c_sum_reg   <= c_sum_next;
            c_wdata_reg <= b_off;
            c_wr_reg    <= c_wr_next;
            d_type_reg  <= c_type_reg;
            d_step_reg  <= c_addr_reg;
            d_sum_reg   <= c_sum_reg;
        end
    end

    // ----------------------------------------------------------- offset table
    // Writes and reads happen in the same stage, so a later item always sees
    // every earlier write.
    always_comb
    begin
        if (clr_active_reg)
        begin
            ram_we    = 1'b1;
            ram_waddr = clr_addr_reg;
            ram_wdata = '0;
        end
        else
        begin
            ram_we    = en && c_valid_reg && c_wr_reg;
            ram_waddr = c_addr_reg;
            ram_wdata = c_wdata_reg;
        end
    end

    gtq_ram #(
        .WIDTH (OFF_W),
        .DEPTH (MAX_STEPS)
    ) u_offset_ram (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_en   (en),
        .rd_addr (c_addr_reg),
        .rd_data (ram_rdata)
    );

    // ---------------------------------------------------------- result stage
    assign off_s = $signed(ram_rdata);
    assign res   = $signed(RES_W'(d_sum_reg)) + RES_W'(off_s);

    always_comb
    begin
        priority if (d_type_reg == gtq_pkg::REQ_WRITE)
        begin
            q_val = '0;
            clamp = 1'b0;
        end
        else if (res < 0)
        begin
            q_val = '0;
            clamp = 1'b1;
        end
        else if (res > $signed(RES_W'(POS_MAX)))
        begin
            q_val = POS_MAX;
            clamp = 1'b1;
        end
        else
        begin
            q_val = PW'(res);
            clamp = 1'b0;
        end
    end

    assign new_data = gtq_pkg::M_TDATA_W'({clamp,
                                          (d_type_reg == gtq_pkg::REQ_WRITE) ?
                                          gtq_pkg::STEP_FIELD_W'(0) :
                                          gtq_pkg::STEP_FIELD_W'(d_step_reg),
                                          gtq_pkg::POS_FIELD_W'(q_val)});
    assign new_valid = en && d_valid_reg;

    // ------------------------------------------------------- output and skid
    assign take = out_valid_reg && m_tready;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (skid_valid_reg)
        begin
            if (take)
            begin
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end
        end
        else
        begin
            if (take)
            begin
                out_valid_next = 1'b0;
            end
            if (new_valid)
            begin
                if (!out_valid_reg || take)
                begin
                    out_data_next  = new_data;
                    out_valid_next = 1'b1;
                end
                else
                begin
                    skid_data_next  = new_data;
                    skid_valid_next = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

@@ rtl/core/gtq_checker.sv @@
// Port-level checker of the groove template quantizer and its bind.
`include "groove_template_quantizer_macros.svh"

module gtq_checker #(
    parameter int MAX_STEPS     = gtq_pkg::MAX_STEPS_DEF,
    parameter int POSITION_BITS = gtq_pkg::POSITION_BITS_DEF
) (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          s_tready,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [gtq_pkg::M_TDATA_W-1:0] m_tdata
);

    localparam int PW = (POSITION_BITS < gtq_pkg::POS_FIELD_W) ?
                        POSITION_BITS : gtq_pkg::POS_FIELD_W;
    localparam logic [gtq_pkg::POS_FIELD_W-1:0] POS_MAX =
        gtq_pkg::POS_FIELD_W'((64'd1 << PW) - 64'd1);

    // A stalled result must be held unchanged.
    `GTQ_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result changed while stalled")

    // Input readiness only drops when a result is already waiting at the output.
    `GTQ_ASSERT_NOW(a_ready_drop, $fell(s_tready), m_tvalid, "s_tready fell with no pending result")

    // A clamped result sits at zero or at the top of the position range.
    `GTQ_ASSERT_NOW(a_clamp_value, m_tvalid && m_tdata[40], m_tdata[31:0] == '0 || m_tdata[31:0] == POS_MAX, "clamped result not at a range limit")

    // The chosen step is always inside the table.
    `GTQ_ASSERT_NOW(a_step_range, m_tvalid, 32'(m_tdata[39:32]) < 32'(MAX_STEPS), "chosen step outside the table")

endmodule

bind groove_template_quantizer gtq_checker #(
    .MAX_STEPS     (MAX_STEPS),
    .POSITION_BITS (POSITION_BITS)
) u_gtq_checker (.*);

@@ tb/groove_template_quantizer_test.sv @@
// Self-checking testbench for the groove template quantizer.
module groove_template_quantizer_test;

    timeunit 1ns;
    timeprecision 1ps;

    import gtq_pkg::*;

    localparam int          PIPE_LATENCY    = POSITION_BITS_DEF + $clog2(MAX_STEPS_DEF) + 5;
    localparam int          CYCLE_LIMIT     = 300000;
    localparam int          RANDOM_PHASES   = 8;
    localparam int          ITEMS_PER_PHASE = 175;
    localparam longint      POS_LIMIT       = (64'd1 << POSITION_BITS_DEF) - 64'd1;
    localparam logic [16:0] OFFSET_MIN      = 17'h1_0000;
    localparam logic [16:0] OFFSET_MAX      = 17'h0_FFFF;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED_LOW  = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED_HIGH = 8'hFF;

    typedef struct packed
    {
        logic [31:0] quantized_position;
        logic [7:0]  chosen_step;
        logic        clamped;
    } quant_result_t;

    logic                    clk = 1'b0;
    logic                    rst_n;
    logic                    s_tvalid;
    logic                    s_tready;
    logic [S_TDATA_W-1:0]    s_tdata;
    logic                    s_tuser;
    logic                    m_tvalid;
    logic                    m_tready;
    logic [M_TDATA_W-1:0]    m_tdata;
    logic                    cfg_valid;
    logic                    cfg_ready;
    logic [CFG_IDX_W-1:0]    cfg_index;
    logic [CFG_DATA_W-1:0]   cfg_data;

    logic [TR_W-1:0]         tick_raster_q = TR_W'(TR_RESET);
    logic [SC_W-1:0]         step_count_q  = SC_W'(SC_RESET);
    logic signed [OFF_W-1:0] groove_offsets [0:MAX_STEPS_DEF-1];
    quant_result_t           pending_results [$];

    bit                      steady_tail    = 1'b0;
    int unsigned             mismatch_count = 0;
    int unsigned             result_count   = 0;
    int unsigned             quantize_count = 0;
    int unsigned             write_count    = 0;
    int unsigned             setting_count  = 0;
    int unsigned             cycle_count    = 0;

    groove_template_quantizer dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles with %0d results outstanding",
                     cycle_count, pending_results.size());
            $display("Mismatches found");
            $finish;
        end
    end

    function automatic void grid_size(output longint unsigned raster,
                                      output longint unsigned steps);
        raster = (tick_raster_q == '0) ? 64'd1 : longint'(tick_raster_q);
        steps  = (step_count_q == '0) ? 64'd1 : longint'(step_count_q);
        if (steps > MAX_STEPS_DEF)
            steps = MAX_STEPS_DEF;
    endfunction

    function automatic quant_result_t predict_quantize(input logic [31:0] pos);
        longint unsigned raster;
        longint unsigned steps;
        longint unsigned cycle_len;
        longint unsigned pos_w;
        longint unsigned base;
        longint unsigned rem;
        longint unsigned step;
        longint unsigned start;
        longint          total;
        quant_result_t   r;
        grid_size(raster, steps);
        cycle_len = steps * raster;
        pos_w     = longint'(pos) & POS_LIMIT;
        base      = (pos_w / cycle_len) * cycle_len;
        rem       = pos_w - base;
        step      = rem / raster;
        if (step >= steps)
            step = steps - 1;
        start = step * raster;
        if (start + raster / 2 < rem)
        begin
            step = step + 1;
            if (step >= steps)
            begin
                step = 0;
                base = base + cycle_len;
            end
            start = step * raster;
        end
        total = $signed(base + start) + longint'(groove_offsets[step[7:0]]);
        r.chosen_step = step[7:0];
        if (total < 0)
        begin
            r.quantized_position = '0;
            r.clamped            = 1'b1;
        end
        else if (total > POS_LIMIT)
        begin
            r.quantized_position = POS_LIMIT[31:0];
            r.clamped            = 1'b1;
        end
        else
        begin
            r.quantized_position = total[31:0];
            r.clamped            = 1'b0;
        end
        return r;
    endfunction

    task automatic report_mismatch(input string what, input longint unsigned got,
                                   input longint unsigned want);
        $display("MISMATCH at result %0d: %s is 0x%0h, expected 0x%0h",
                 result_count, what, got, want);
        mismatch_count++;
    endtask

    always @(posedge clk)
    begin : check_results
        quant_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_results.size() == 0)
                report_mismatch("unexpected result item", 64'(m_tdata), 64'd0);
            else
            begin
                want = pending_results.pop_front();
                if (m_tdata[31:0] !== want.quantized_position)
                    report_mismatch("quantized_position", 64'(m_tdata[31:0]),
                                    64'(want.quantized_position));
                if (m_tdata[39:32] !== want.chosen_step)
                    report_mismatch("chosen_step", 64'(m_tdata[39:32]),
                                    64'(want.chosen_step));
                if (m_tdata[40] !== want.clamped)
                    report_mismatch("clamped", 64'(m_tdata[40]), 64'(want.clamped));
            end
            result_count++;
        end
    end

    initial
    begin : receiver
        m_tready = 1'b0;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            m_tready <= 1'b1;
            repeat ($urandom_range(1, 16)) @(posedge clk);
            if (!steady_tail && $urandom_range(0, 2) == 0)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 11)) @(posedge clk);
            end
        end
    end

    task automatic send_item(input req_type_t kind, input logic [31:0] pos,
                             input logic [7:0] idx, input logic signed [16:0] off);
        if (!steady_tail && $urandom_range(0, 4) == 0)
        begin
            if (s_tvalid)
                s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {7'd0, off, idx, pos};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        if (kind == REQ_WRITE)
        begin
            groove_offsets[idx] = off;
            pending_results.push_back('0);
            write_count++;
        end
        else
        begin
            pending_results.push_back(predict_quantize(pos));
            quantize_count++;
        end
    endtask

    task automatic send_quantize(input logic [31:0] pos);
        send_item(REQ_QUANTIZE, pos, 8'($urandom_range(0, 255)), 17'($urandom));
    endtask

    task automatic send_offset_write(input logic [7:0] idx, input logic [16:0] off);
        send_item(REQ_WRITE, $urandom, idx, off);
    endtask

    task automatic wait_for_results();
        if (s_tvalid)
            s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] index,
                                  input logic [CFG_DATA_W-1:0] value, input bit last);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        if (last)
            cfg_valid <= 1'b0;
        if (index == REG_TICK_RASTER)
            tick_raster_q = value;
        else if (index == REG_STEP_COUNT)
            step_count_q = value[SC_W-1:0];
        setting_count++;
    endtask

    function automatic logic [CFG_DATA_W-1:0] pick_raster();
        int unsigned sel;
        sel = $urandom_range(0, 99);
        if (sel < 10)
            return 16'd0;
        if (sel < 20)
            return 16'd1;
        if (sel < 30)
            return 16'hFFFF;
        if (sel < 40)
            return CFG_DATA_W'($urandom_range(0, 65535));
        return CFG_DATA_W'($urandom_range(2, 1000));
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_step_count();
        int unsigned sel;
        sel = $urandom_range(0, 99);
        if (sel < 10)
            return 16'd0;
        if (sel < 20)
            return 16'd1;
        if (sel < 30)
            return 16'd256;
        if (sel < 40)
            return CFG_DATA_W'($urandom_range(257, 511));
        if (sel < 50)
            return CFG_DATA_W'($urandom_range(0, 65535));
        return CFG_DATA_W'($urandom_range(2, 40));
    endfunction

    function automatic logic [7:0] pick_index();
        longint unsigned raster;
        longint unsigned steps;
        grid_size(raster, steps);
        if ($urandom_range(0, 9) < 7)
            return 8'($urandom_range(0, 32'(steps - 1)));
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic logic [16:0] pick_offset();
        int unsigned sel;
        sel = $urandom_range(0, 9);
        if (sel == 0)
            return OFFSET_MIN;
        if (sel == 1)
            return OFFSET_MAX;
        if (sel == 2)
            return 17'd0;
        return 17'($urandom);
    endfunction

    function automatic logic [31:0] pick_position();
        longint unsigned raster;
        longint unsigned steps;
        longint unsigned cycle_len;
        longint unsigned k;
        longint unsigned p;
        int unsigned     sel;
        grid_size(raster, steps);
        cycle_len = raster * steps;
        if ($urandom_range(0, 1) == 0)
            k = 64'($urandom_range(0, 3));
        else
            k = 64'($urandom_range(0, 32'(64'hFFFF_FFFF / cycle_len)));
        sel = $urandom_range(0, 99);
        if (sel < 35)
            p = k * cycle_len + 64'($urandom_range(0, 32'(steps - 1))) * raster + raster / 2
                + 64'($urandom_range(0, 3)) - 1;
        else if (sel < 50)
            p = k * cycle_len + cycle_len - 64'($urandom_range(1, 32'(raster)));
        else if (sel < 60)
            p = 64'hFFFF_FFFF - 64'($urandom_range(0, 70000));
        else if (sel < 65)
            p = 64'($urandom_range(0, 1000));
        else
            p = 64'($urandom);
        return p[31:0];
    endfunction

    task automatic test_reset_defaults();
        send_quantize(32'd0);
        send_quantize(32'd240);
        send_quantize(32'd241);
        send_quantize(32'd7679);
        send_quantize(32'hFFFF_FFFF);
    endtask

    task automatic test_offset_table();
        send_offset_write(8'd0, OFFSET_MIN);
        send_offset_write(8'd255, OFFSET_MAX);
        send_offset_write(8'd1, 17'd5);
        send_quantize(32'd0);
        send_quantize(32'd480);
    endtask

    task automatic test_register_extremes();
        wait_for_results();
        write_register(REG_TICK_RASTER, 16'd0, 1'b0);
        write_register(REG_STEP_COUNT, 16'd0, 1'b1);
        send_quantize(32'h8000_0000);
        send_quantize(32'd12345);
        wait_for_results();
        write_register(REG_UNUSED_LOW, 16'hFFFF, 1'b0);
        write_register(REG_UNUSED_HIGH, 16'hFFFF, 1'b1);
        send_quantize(32'd12345);
        wait_for_results();
        write_register(REG_TICK_RASTER, 16'hFFFF, 1'b0);
        write_register(REG_STEP_COUNT, 16'd511, 1'b1);
        send_offset_write(8'd1, OFFSET_MAX);
        send_quantize(32'hFFFF_FFFF);
        send_quantize(32'd16776959);
        wait_for_results();
        write_register(REG_STEP_COUNT, 16'd256, 1'b1);
        send_quantize(32'hFFFF_FFFF);
        send_quantize(32'd16776959);
        send_quantize(32'd32767);
        send_quantize(32'd32768);
    endtask

    task automatic test_random_traffic();
        int unsigned phase;
        int unsigned n;
        for (phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            wait_for_results();
            if (phase == RANDOM_PHASES - 1)
                steady_tail = 1'b1;
            write_register(REG_TICK_RASTER, pick_raster(), 1'b0);
            write_register(REG_STEP_COUNT, pick_step_count(), 1'b1);
            for (n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                if (phase == 2 && n == ITEMS_PER_PHASE / 2)
                    wait_for_results();
                if ($urandom_range(0, 3) == 0)
                    send_offset_write(pick_index(), pick_offset());
                else
                    send_quantize(pick_position());
            end
        end
    endtask

    task automatic finish_run();
        wait_for_results();
        repeat (PIPE_LATENCY + 20) @(posedge clk);
        $display("Checked %0d result items: %0d quantize requests, %0d table writes",
                 result_count, quantize_count, write_count);
        $display("Register writes: %0d, covering zero, unit, full-scale and oversized grids",
                 setting_count);
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    endtask

    initial
    begin
        rst_n     = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        for (int i = 0; i < MAX_STEPS_DEF; i++)
            groove_offsets[i] = '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        test_reset_defaults();
        test_offset_table();
        test_register_extremes();
        test_random_traffic();
        finish_run();
    end

endmodule
